// ===== sv/lcbe_pkg.sv =====
// Shared types, constants and the cosine table for the lidar beacon extractor.
// No dependencies; every other file imports this package.
package lcbe_pkg;

	localparam int DIST_W    = 18;
	localparam int ANG_W     = 16;
	localparam int SUM_W     = 22;
	localparam int CNT_W     = 7;
	localparam int LIM_W     = 12;
	localparam int COS_N     = 1024;
	localparam int COS_AW    = $clog2(COS_N);
	localparam int CQ_DEPTH  = 2;
	localparam int CQ_AW     = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH  = 4;
	localparam int RQ_AW     = $clog2(RQ_DEPTH);
	localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(64);

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	typedef enum logic [2:0] {
		REG_JOIN   = 3'd0,
		REG_VRANGE = 3'd1,
		REG_BRANGE = 3'd2,
		REG_DIAM   = 3'd3,
		REG_TOL    = 3'd4,
		REG_MAXPTS = 3'd5,
		REG_RADIUS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] join_mm;
		logic [15:0] vrange_mm;
		logic [15:0] brange_mm;
		logic [9:0]  diam_mm;
		logic [9:0]  tol_mm;
		logic [5:0]  max_pts;
		logic [8:0]  radius_mm;
	} cfg_t;

	typedef enum logic [1:0] {
		K_OPEN  = 2'd0,
		K_POINT = 2'd1,
		K_END   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [DIST_W-1:0] dist_q2;
		logic [ANG_W-1:0]  angle;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] a;
		logic [DIST_W-1:0] b;
		logic [ANG_W-1:0]  delta;
		logic [LIM_W-1:0]  m1;
		logic [LIM_W-1:0]  m2;
		logic              use_lt;
	} chord_req_t;

	typedef struct packed {
		logic done;
		logic gt;
		logic lt;
	} chord_res_t;

	typedef struct packed {
		logic        is_end;
		logic [18:0] dist_q2;
		logic [15:0] angle;
		logic [7:0]  count;
		logic        last;
	} res_t;

	typedef logic signed [16:0] cos_tab_t [COS_N];

	function automatic longint cos_q30_quad(longint x);
		longint unsigned ux;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		ux = longint'(x);
		x2 = (ux * ux) >> 30;
		term = ONE_Q30;
		sum = ONE_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) sum = 0;
		if (sum > ONE_Q30) sum = ONE_Q30;
		return sum;
	endfunction

	function automatic logic signed [16:0] cos_entry(int k);
		longint q;
		longint r;
		longint x;
		longint c;
		q = (4 * longint'(k)) / COS_N;
		r = 4 * longint'(k) - q * COS_N;
		x = (HALF_PI_Q30 * r) / COS_N;
		if (q == 1 || q == 3) x = HALF_PI_Q30 - x;
		c = (cos_q30_quad(x) + 16384) >>> 15;
		if (q == 1 || q == 2) c = -c;
		return 17'(c);
	endfunction

	function automatic cos_tab_t cos_build();
		cos_tab_t t;
		for (int k = 0; k < COS_N; k++) begin
			t[k] = cos_entry(k);
		end
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = cos_build();

endpackage

// ===== sv/lcbe_front.sv =====
// Front end: accepts scan points, classifies them and queues commands.
// Depends on lcbe_pkg.
module lcbe_front import lcbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [DIST_W-1:0] dist_q2,
	input  logic [ANG_W-1:0]  angle_q14,
	input  logic              last_point,
	input  logic [15:0]       vrange_mm,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_q, rd_q;
	logic [CQ_AW:0]   cnt_q;
	logic             scan_q;
	logic             accept, in_range, keep, wr_en, rd_en;
	cmd_t             new_cmd;

	assign full      = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];
	assign accept    = push & ~full;
	assign rd_en     = cmd_pop & cmd_valid;

	always_comb begin
		in_range = (dist_q2 != '0) && (dist_q2 < {vrange_mm, 2'b00});
		keep = scan_q | in_range | last_point;
		new_cmd.dist_q2 = dist_q2;
		new_cmd.angle   = angle_q14;
		new_cmd.last    = last_point;
		if (scan_q) begin
			new_cmd.kind = K_OPEN;
		end else if (in_range) begin
			new_cmd.kind = K_POINT;
		end else begin
			new_cmd.kind = K_END;
		end
	end

	assign wr_en = accept & keep;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			scan_q <= 1'b1;
		end else begin
			// the beat after a last point opens the next scan
			if (accept) scan_q <= last_point;
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lcbe_chord.sv =====
// Chord engine: squared law-of-cosines distance against one or two squared limits,
// one shared 18x18 multiplier over nine steps. Depends on lcbe_pkg.
module lcbe_chord import lcbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  chord_req_t req,
	output chord_res_t res
);

	localparam logic [3:0] STEP_LAST = 4'd8;

	chord_req_t               req_q;
	logic                     busy_q;
	logic [3:0]               step_q;
	logic                     c_neg_q;
	logic [15:0]              c_mag_q;
	logic [35:0]              mul_q;
	logic [36:0]              sq_q;
	logic [35:0]              ab_q;
	logic [23:0]              l1_q, l2_q;
	logic [51:0]              pr_q;
	logic signed [55:0]       t_q;
	logic [16+COS_AW:0]       idx_w;
	logic [COS_AW-1:0]        cos_idx;
	logic signed [16:0]       cos_val;
	logic [16:0]              cos_abs;
	logic [17:0]              x_w, y_w;
	logic signed [55:0]       sq_w, pr_w, lim1_w, lim2_w;

	always_comb begin
		idx_w   = {1'b0, req_q.delta, COS_AW'(0)} + (17+COS_AW)'(32768);
		cos_idx = idx_w[16 +: COS_AW];
		cos_val = COS_TAB[cos_idx];
		cos_abs = cos_val[16] ? 17'(-cos_val) : 17'(cos_val);
	end

	always_comb begin
		case (step_q)
			4'd0: begin x_w = req_q.a; y_w = req_q.a; end
			4'd1: begin x_w = req_q.b; y_w = req_q.b; end
			4'd2: begin x_w = req_q.a; y_w = req_q.b; end
			4'd3: begin x_w = 18'(req_q.m1); y_w = 18'(req_q.m1); end
			4'd4: begin x_w = ab_q[17:0]; y_w = 18'(c_mag_q); end
			4'd5: begin x_w = ab_q[35:18]; y_w = 18'(c_mag_q); end
			4'd6: begin x_w = 18'(req_q.m2); y_w = 18'(req_q.m2); end
			default: begin x_w = '0; y_w = '0; end
		endcase
	end

	always_comb begin
		sq_w   = $signed({4'b0, sq_q, 15'b0});
		pr_w   = $signed({3'b0, pr_q, 1'b0});
		lim1_w = $signed({13'b0, l1_q, 19'b0});
		lim2_w = $signed({13'b0, l2_q, 19'b0});
		res.done = busy_q && (step_q == STEP_LAST);
		res.gt   = t_q > lim1_w;
		res.lt   = req_q.use_lt && (t_q < lim2_w);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
		end
		if (busy_q) begin
			mul_q <= 36'(x_w) * 36'(y_w);
			case (step_q)
				4'd0: begin
					c_neg_q <= cos_val[16];
					c_mag_q <= cos_abs[15:0];
				end
				4'd1: sq_q <= 37'(mul_q);
				4'd2: sq_q <= sq_q + 37'(mul_q);
				4'd3: ab_q <= mul_q;
				4'd4: l1_q <= mul_q[23:0];
				4'd5: pr_q <= 52'(mul_q);
				4'd6: pr_q <= pr_q + {mul_q[33:0], 18'b0};
				4'd7: begin
					l2_q <= mul_q[23:0];
					// negative cosine widens the chord
					t_q  <= c_neg_q ? (sq_w + pr_w) : (sq_w - pr_w);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/lcbe_div.sv =====
// Restoring divider for the mean angle: one quotient bit per cycle.
// Depends on lcbe_pkg.
module lcbe_div import lcbe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] quo
);

	localparam int IW = $clog2(SUM_W);

	logic [CNT_W-1:0] den_q, rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [IW-1:0]    it_q;
	logic             busy_q, done_q;
	logic [CNT_W:0]   trial, diff;
	logic             fit;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == IW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/lcbe_back.sv =====
// Back end: cluster state, join and beacon sequencing, result queue.
// Depends on lcbe_pkg, lcbe_chord and lcbe_div.
module lcbe_back import lcbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_empty,
	output res_t res_head,
	input  logic res_pop
);

	typedef enum logic [7:0] {
		B_IDLE  = 8'b0000_0001,
		B_JOIN  = 8'b0000_0010,
		B_TEST  = 8'b0000_0100,
		B_CHORD = 8'b0000_1000,
		B_DIV   = 8'b0001_0000,
		B_EMIT  = 8'b0010_0000,
		B_NEXT  = 8'b0100_0000,
		B_END   = 8'b1000_0000
	} bstate_t;

	bstate_t           state_q;
	cmd_t              cur_q;
	logic              final_q;
	logic [DIST_W-1:0] prev_d_q, first_d_q, near_q;
	logic [ANG_W-1:0]  prev_a_q, first_a_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        found_q;

	res_t              rq_mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]  rq_wr_q, rq_rd_q;
	logic [RQ_AW:0]    rq_cnt_q;
	logic              rq_full, rq_wr, rq_rd;
	res_t              rq_data;

	chord_req_t        ch_req;
	chord_res_t        ch_res;
	logic              ch_start, div_start, div_done;
	logic [SUM_W-1:0]  div_quo;
	logic              basic_ok;
	logic [10:0]       d_plus_t;

	lcbe_chord u_chord (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ch_start),
		.req    (ch_req),
		.res    (ch_res)
	);

	lcbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (cnt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign rq_full   = (rq_cnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign res_empty = (rq_cnt_q == '0);
	assign res_head  = rq_mem_q[rq_rd_q];
	assign rq_rd     = res_pop & ~res_empty;

	always_comb begin
		basic_ok = (cnt_q != '0) && (cnt_q <= CNT_W'(cfg.max_pts))
			&& (first_d_q <= {cfg.brange_mm, 2'b00});
		d_plus_t = 11'(cfg.diam_mm) + 11'(cfg.tol_mm);
		cmd_pop  = (state_q == B_IDLE) && cmd_valid;

		ch_start = 1'b0;
		ch_req   = '0;
		if (state_q == B_IDLE) begin
			ch_start     = cmd_valid && (cmd.kind == K_POINT);
			ch_req.a     = prev_d_q;
			ch_req.b     = cmd.dist_q2;
			ch_req.delta = cmd.angle - prev_a_q;
			ch_req.m1    = cfg.join_mm;
		end else begin
			ch_start     = (state_q == B_TEST) && basic_ok && (cnt_q != CNT_W'(1));
			ch_req.a     = first_d_q;
			ch_req.b     = prev_d_q;
			ch_req.delta = prev_a_q - first_a_q;
			ch_req.m1    = LIM_W'(d_plus_t);
			ch_req.m2    = LIM_W'(cfg.diam_mm - cfg.tol_mm);
			ch_req.use_lt = cfg.diam_mm > cfg.tol_mm;
		end

		div_start = ((state_q == B_TEST) && basic_ok && (cnt_q == CNT_W'(1)))
			|| ((state_q == B_CHORD) && ch_res.done && !ch_res.gt && !ch_res.lt);

		rq_wr   = 1'b0;
		rq_data = '0;
		if (state_q == B_EMIT) begin
			rq_wr           = ~rq_full;
			rq_data.dist_q2 = 19'(near_q) + {8'b0, cfg.radius_mm, 2'b00};
			rq_data.angle   = div_quo[15:0];
			// a beacon closed by a gap is last only when no end marker follows
			rq_data.last    = ~final_q & ~cur_q.last;
		end else if (state_q == B_END) begin
			rq_wr          = ~rq_full;
			rq_data.is_end = 1'b1;
			rq_data.count  = found_q;
			rq_data.last   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rq_wr) begin
			rq_mem_q[rq_wr_q] <= rq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_wr) rq_wr_q <= rq_wr_q + 1'b1;
			if (rq_rd) rq_rd_q <= rq_rd_q + 1'b1;
			if (rq_wr && !rq_rd) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (!rq_wr && rq_rd) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cur_q     <= '0;
			final_q   <= 1'b0;
			prev_d_q  <= '0;
			prev_a_q  <= '0;
			first_d_q <= '0;
			first_a_q <= '0;
			near_q    <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			found_q   <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						final_q <= cmd.last;
						case (cmd.kind)
							K_OPEN: begin
								found_q   <= '0;
								first_d_q <= cmd.dist_q2;
								first_a_q <= cmd.angle;
								prev_d_q  <= cmd.dist_q2;
								prev_a_q  <= cmd.angle;
								near_q    <= cmd.dist_q2;
								sum_q     <= SUM_W'(cmd.angle);
								cnt_q     <= CNT_W'(1);
								state_q   <= cmd.last ? B_TEST : B_IDLE;
							end
							K_POINT: begin
								final_q <= 1'b0;
								state_q <= B_JOIN;
							end
							default: state_q <= B_TEST;
						endcase
					end
				end
				B_JOIN: begin
					if (ch_res.done) begin
						if (ch_res.gt) begin
							state_q <= B_TEST;
						end else begin
							prev_d_q <= cur_q.dist_q2;
							prev_a_q <= cur_q.angle;
							if (cur_q.dist_q2 < near_q) near_q <= cur_q.dist_q2;
							if (cnt_q < COUNT_SAT) begin
								sum_q <= sum_q + SUM_W'(cur_q.angle);
								cnt_q <= cnt_q + 1'b1;
							end
							final_q <= cur_q.last;
							state_q <= cur_q.last ? B_TEST : B_IDLE;
						end
					end
				end
				B_TEST: begin
					if (!basic_ok) begin
						state_q <= B_NEXT;
					end else if (cnt_q == CNT_W'(1)) begin
						state_q <= B_DIV;
					end else begin
						state_q <= B_CHORD;
					end
				end
				B_CHORD: begin
					if (ch_res.done) begin
						state_q <= (ch_res.gt || ch_res.lt) ? B_NEXT : B_DIV;
					end
				end
				B_DIV: begin
					if (div_done) state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!rq_full) begin
						if (found_q != 8'hFF) found_q <= found_q + 1'b1;
						state_q <= B_NEXT;
					end
				end
				B_NEXT: begin
					if (final_q) begin
						state_q <= B_END;
					end else begin
						// open a fresh cluster at the point that broke the gap
						first_d_q <= cur_q.dist_q2;
						first_a_q <= cur_q.angle;
						prev_d_q  <= cur_q.dist_q2;
						prev_a_q  <= cur_q.angle;
						near_q    <= cur_q.dist_q2;
						sum_q     <= SUM_W'(cur_q.angle);
						cnt_q     <= CNT_W'(1);
						final_q   <= cur_q.last;
						state_q   <= cur_q.last ? B_TEST : B_IDLE;
					end
				end
				B_END: begin
					if (!rq_full) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/lidar_cluster_beacon_extract.sv =====
// Lidar scan clustering and beacon extraction, queue ports on both sides.
// A point is registered in the command queue and reaches the back end once it heads the queue;
// there a cluster is opened in the idle state and a join runs the nine-step chord engine.
// Closing a beacon runs the chord test and then the divider, or the divider alone for a single
// point; the end marker closes the scan. Sustained rate is set by the back end, lower while the result queue is full.
// Reset clears all control and cluster state and loads the register defaults.
module lidar_cluster_beacon_extract import lcbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [DIST_W-1:0] dist_q2,
	input  logic [ANG_W-1:0]  angle_q14,
	input  logic              last_point,
	output logic              empty,
	input  logic              pop,
	output logic              is_end_marker,
	output logic [18:0]       beacon_dist_q2,
	output logic [15:0]       beacon_angle_q14,
	output logic [7:0]        beacon_count,
	output logic              last_of_run,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	cfg_t cfg_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	res_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.join_mm   <= 12'd50;
			cfg_q.vrange_mm <= 16'd3300;
			cfg_q.brange_mm <= 16'd3500;
			cfg_q.diam_mm   <= 10'd50;
			cfg_q.tol_mm    <= 10'd53;
			cfg_q.max_pts   <= 6'd35;
			cfg_q.radius_mm <= 9'd25;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_JOIN:   cfg_q.join_mm   <= cfg_data[11:0];
				REG_VRANGE: cfg_q.vrange_mm <= cfg_data;
				REG_BRANGE: cfg_q.brange_mm <= cfg_data;
				REG_DIAM:   cfg_q.diam_mm   <= cfg_data[9:0];
				REG_TOL:    cfg_q.tol_mm    <= cfg_data[9:0];
				REG_MAXPTS: cfg_q.max_pts   <= cfg_data[5:0];
				REG_RADIUS: cfg_q.radius_mm <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	lcbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.dist_q2    (dist_q2),
		.angle_q14  (angle_q14),
		.last_point (last_point),
		.vrange_mm  (cfg_q.vrange_mm),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	lcbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_empty (empty),
		.res_head  (head),
		.res_pop   (pop)
	);

	assign is_end_marker    = head.is_end;
	assign beacon_dist_q2   = head.dist_q2;
	assign beacon_angle_q14 = head.angle;
	assign beacon_count     = head.count;
	assign last_of_run      = head.last;

endmodule
